@@ src/fteh_pkg.sv @@
package fteh_pkg;

    // Protocol codes
    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    // TCP flag positions
    localparam int unsigned FLAG_PSH_BIT = 3;
    localparam int unsigned FLAG_URG_BIT = 5;

    // Seed after reset
    localparam logic [31:0] SEED_RESET = 32'd16;

    // Murmur3 x86_32 constants
    localparam logic [31:0] MM_C1    = 32'hcc9e2d51;
    localparam logic [31:0] MM_C2    = 32'h1b873593;
    localparam logic [31:0] MM_ADD   = 32'he6546b64;
    localparam logic [31:0] MM_LEN   = 32'd5;
    localparam logic [31:0] MM_FMIX1 = 32'h85ebca6b;
    localparam logic [31:0] MM_FMIX2 = 32'hc2b2ae35;

    // Pipeline depth
    localparam int unsigned NUM_STAGES = 7;

    // Record fields carried down the pipeline beside the hash
    typedef struct packed {
        logic        valid;
        logic [7:0]  proto;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] src_l4_port;
        logic [15:0] dst_l4_port;
        logic        push;
        logic        urgent;
        logic [15:0] len;
    } rec_t;

    // Rotate left by a constant amount
    function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned r);
        logic [63:0] dbl;
        dbl = {x, x} << r;
        return dbl[63:32];
    endfunction

endpackage

@@ src/flow_tuple_extract_hash_top.sv @@
// Channel | Handshake            | Payload
// --------+----------------------+----------------------------------------------
// input   | in_valid / in_ready  | ip_proto src_ip dst_ip src_l4_port dst_l4_port
//         |                      | l4_flags frame_len
// output  | out_valid/ out_ready | rec_valid rec_proto rec_src_ip rec_dst_ip
//         |                      | rec_src_port rec_dst_port push_flag
//         |                      | urgent_flag rec_len flow_hash
// config  | cfg_wr_en            | cfg_wr_data (hash seed)
//
// One item per cycle while out_ready does not stall it; seven stages, and
// the result is taken at the edge on which out_valid and out_ready are high.
// Depth is set by the chain of four dependent 32-bit multiplies in the hash,
// each followed by a register.
// Reset (rst_n, async, active low) empties the pipeline and loads seed 16.
// Each stage holds its item while the next one is full and stalled; bubbles
// close up, so input is still taken while a result waits at the output.

module flow_tuple_extract_hash_top
    import fteh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  ip_proto,
    input  logic [31:0] src_ip,
    input  logic [31:0] dst_ip,
    input  logic [15:0] src_l4_port,
    input  logic [15:0] dst_l4_port,
    input  logic [7:0]  l4_flags,
    input  logic [15:0] frame_len,

    output logic        out_valid,
    input  logic        out_ready,
    output logic        rec_valid,
    output logic [7:0]  rec_proto,
    output logic [31:0] rec_src_ip,
    output logic [31:0] rec_dst_ip,
    output logic [15:0] rec_src_port,
    output logic [15:0] rec_dst_port,
    output logic        push_flag,
    output logic        urgent_flag,
    output logic [15:0] rec_len,
    output logic [31:0] flow_hash
);

    logic [31:0] seed_reg;

    logic [NUM_STAGES:1] vld_reg;
    logic [NUM_STAGES:1] vld_next;
    logic [NUM_STAGES:1] stage_rdy;

    rec_t rec_reg [1:NUM_STAGES];
    rec_t rec_next;

    logic [31:0] k1_reg, k1_next;
    logic [7:0]  k2_reg, k2_next;
    logic [31:0] m1_reg, m1_next;
    logic [31:0] m2_reg, m2_next;
    logic [31:0] b1_reg, b1_next;
    logic [31:0] b2_reg, b2_next;
    logic [31:0] h4_reg, h4_next;
    logic [31:0] h5_reg, h5_next;
    logic [31:0] h6_reg, h6_next;
    logic [31:0] hash_reg, hash_next;

    logic        is_tcp;
    logic        is_valid;
    logic [15:0] port_lo;
    logic [15:0] port_hi;
    logic [31:0] h_rot;
    logic [31:0] h_body;
    logic [31:0] h_tail;
    logic [31:0] h_mid;

    // Seed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= SEED_RESET;
        end
        else if (cfg_wr_en)
        begin
            seed_reg <= cfg_wr_data;
        end
    end

    // Ready chain: a stage takes an item when empty or when it drains
    always_comb
    begin
        stage_rdy[NUM_STAGES] = !vld_reg[NUM_STAGES] || out_ready;
        for (int i = NUM_STAGES - 1; i >= 1; i--)
        begin
            stage_rdy[i] = !vld_reg[i] || stage_rdy[i + 1];
        end
    end

    assign in_ready = stage_rdy[1];

    // Valid bits
    always_comb
    begin
        vld_next[1] = stage_rdy[1] ? in_valid : vld_reg[1];
        for (int i = 2; i <= NUM_STAGES; i++)
        begin
            vld_next[i] = stage_rdy[i] ? vld_reg[i - 1] : vld_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Stage 1: decode, mask fields, build the symmetric key
    always_comb
    begin
        is_tcp   = (ip_proto == PROTO_TCP);
        is_valid = is_tcp || (ip_proto == PROTO_UDP);
        port_lo  = (src_l4_port < dst_l4_port) ? src_l4_port : dst_l4_port;
        port_hi  = (src_l4_port < dst_l4_port) ? dst_l4_port : src_l4_port;

        rec_next.valid       = is_valid;
        rec_next.proto       = ip_proto;
        rec_next.src_ip      = src_ip;
        rec_next.dst_ip      = dst_ip;
        rec_next.src_l4_port = is_valid ? src_l4_port : 16'd0;
        rec_next.dst_l4_port = is_valid ? dst_l4_port : 16'd0;
        rec_next.push        = is_tcp && l4_flags[FLAG_PSH_BIT];
        rec_next.urgent      = is_tcp && l4_flags[FLAG_URG_BIT];
        rec_next.len         = is_valid ? frame_len : 16'd0;

        // key bytes: proto, lo[15:8], lo[7:0], hi[15:8] | hi[7:0], read little-endian
        k1_next = {port_hi[15:8], port_lo[7:0], port_lo[15:8], ip_proto};
        k2_next = port_hi[7:0];
    end

    // Stage 2: first multiply of both blocks
    assign m1_next = k1_reg * MM_C1;
    assign m2_next = {24'd0, k2_reg} * MM_C1;

    // Stage 3: rotate and second multiply
    assign b1_next = rotl32(m1_reg, 15) * MM_C2;
    assign b2_next = rotl32(m2_reg, 15) * MM_C2;

    // Stage 4: body round, tail block, length and first finalise shift
    always_comb
    begin
        h_rot   = rotl32(seed_reg ^ b1_reg, 13);
        h_body  = h_rot + (h_rot << 2) + MM_ADD;
        h_tail  = h_body ^ b2_reg ^ MM_LEN;
        h4_next = h_tail ^ (h_tail >> 16);
    end

    // Stage 5: finalise multiply one
    assign h5_next = h4_reg * MM_FMIX1;

    // Stage 6: finalise multiply two
    always_comb
    begin
        h_mid   = h5_reg ^ (h5_reg >> 13);
        h6_next = h_mid * MM_FMIX2;
    end

    // Stage 7: last shift, zero for invalid records
    assign hash_next = rec_reg[NUM_STAGES - 1].valid ? (h6_reg ^ (h6_reg >> 16)) : 32'd0;

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (stage_rdy[1])
        begin
            rec_reg[1] <= rec_next;
            k1_reg     <= k1_next;
            k2_reg     <= k2_next;
        end
        for (int i = 2; i <= NUM_STAGES; i++)
        begin
            if (stage_rdy[i])
            begin
                rec_reg[i] <= rec_reg[i - 1];
            end
        end
        if (stage_rdy[2])
        begin
            m1_reg <= m1_next;
            m2_reg <= m2_next;
        end
        if (stage_rdy[3])
        begin
            b1_reg <= b1_next;
            b2_reg <= b2_next;
        end
        if (stage_rdy[4])
        begin
            h4_reg <= h4_next;
        end
        if (stage_rdy[5])
        begin
            h5_reg <= h5_next;
        end
        if (stage_rdy[6])
        begin
            h6_reg <= h6_next;
        end
        if (stage_rdy[7])
        begin
            hash_reg <= hash_next;
        end
    end

    // Outputs
    assign out_valid    = vld_reg[NUM_STAGES];
    assign rec_valid    = rec_reg[NUM_STAGES].valid;
    assign rec_proto    = rec_reg[NUM_STAGES].proto;
    assign rec_src_ip   = rec_reg[NUM_STAGES].src_ip;
    assign rec_dst_ip   = rec_reg[NUM_STAGES].dst_ip;
    assign rec_src_port = rec_reg[NUM_STAGES].src_l4_port;
    assign rec_dst_port = rec_reg[NUM_STAGES].dst_l4_port;
    assign push_flag    = rec_reg[NUM_STAGES].push;
    assign urgent_flag  = rec_reg[NUM_STAGES].urgent;
    assign rec_len      = rec_reg[NUM_STAGES].len;
    assign flow_hash    = hash_reg;

`ifndef SYNTHESIS
    // Accepted item lands in the first stage
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> vld_reg[1])
        else $error("accepted item not held in first stage");

    // Invalid record carries zero hash, ports and length
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !rec_valid |-> flow_hash == 32'd0 && rec_len == 16'd0 &&
        rec_src_port == 16'd0 && rec_dst_port == 16'd0)
        else $error("invalid record with non-zero fields");

    // Flags only set for TCP
    a_flags_tcp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (push_flag || urgent_flag) |-> rec_proto == PROTO_TCP)
        else $error("flag set on non-TCP record");

    // Valid record only for TCP or UDP
    a_valid_proto: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rec_valid |-> rec_proto == PROTO_TCP || rec_proto == PROTO_UDP)
        else $error("valid record with wrong protocol");
`endif

endmodule

@@ sim/flow_tuple_extract_hash_checker.sv @@
module flow_tuple_extract_hash_checker
    import fteh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,

    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  ip_proto,
    input  logic [31:0] src_ip,
    input  logic [31:0] dst_ip,
    input  logic [15:0] src_l4_port,
    input  logic [15:0] dst_l4_port,
    input  logic [7:0]  l4_flags,
    input  logic [15:0] frame_len,

    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        rec_valid,
    input  logic [7:0]  rec_proto,
    input  logic [31:0] rec_src_ip,
    input  logic [31:0] rec_dst_ip,
    input  logic [15:0] rec_src_port,
    input  logic [15:0] rec_dst_port,
    input  logic        push_flag,
    input  logic        urgent_flag,
    input  logic [15:0] rec_len,
    input  logic [31:0] flow_hash,

    output int          fail_count,
    output int          pending_records,
    output int          records_checked,
    output int          valid_records
);

    // Seed after reset and TCP flag masks
    localparam logic [31:0] SEED_AFTER_RESET = 32'd16;
    localparam logic [7:0]  PSH_MASK         = 8'h08;
    localparam logic [7:0]  URG_MASK         = 8'h20;

    // Murmur3 x86_32 mixing constants
    localparam logic [31:0] MIX_C1    = 32'hcc9e2d51;
    localparam logic [31:0] MIX_C2    = 32'h1b873593;
    localparam logic [31:0] STEP_MUL  = 32'd5;
    localparam logic [31:0] STEP_ADD  = 32'he6546b64;
    localparam logic [31:0] KEY_BYTES = 32'd5;
    localparam logic [31:0] FINAL_M1  = 32'h85ebca6b;
    localparam logic [31:0] FINAL_M2  = 32'hc2b2ae35;

    typedef struct packed {
        rec_t        rec;
        logic [31:0] hash;
    } flow_result_t;

    flow_result_t expected_records[$];
    flow_result_t observed;
    flow_result_t oldest;
    logic [31:0]  seed_now;

    // Block scramble: multiply, rotate by 15, multiply
    function automatic logic [31:0] mix_word(input logic [31:0] k);
        logic [31:0] t;
        t = k * MIX_C1;
        t = (t << 15) | (t >> 17);
        return t * MIX_C2;
    endfunction

    // Hash of the key proto, lo port, hi port (ports big-endian)
    function automatic logic [31:0] flow_key_hash(input logic [7:0] proto,
                                                  input logic [15:0] lo,
                                                  input logic [15:0] hi,
                                                  input logic [31:0] seed);
        logic [31:0] h;
        h = seed ^ mix_word({hi[15:8], lo[7:0], lo[15:8], proto});
        h = (h << 13) | (h >> 19);
        h = h * STEP_MUL + STEP_ADD;
        // tail: the single last key byte
        h = h ^ mix_word({24'd0, hi[7:0]});
        h = h ^ KEY_BYTES;
        h = h ^ (h >> 16);
        h = h * FINAL_M1;
        h = h ^ (h >> 13);
        h = h * FINAL_M2;
        h = h ^ (h >> 16);
        return h;
    endfunction

    function automatic flow_result_t predict_record(input logic [7:0] proto,
                                                    input logic [31:0] sip,
                                                    input logic [31:0] dip,
                                                    input logic [15:0] sp,
                                                    input logic [15:0] dp,
                                                    input logic [7:0] flags,
                                                    input logic [15:0] len,
                                                    input logic [31:0] seed);
        flow_result_t r;
        logic         is_tcp;
        logic         known;
        logic [15:0]  lo;
        logic [15:0]  hi;
        is_tcp = (proto == PROTO_TCP);
        known  = is_tcp || (proto == PROTO_UDP);
        lo     = (sp < dp) ? sp : dp;
        hi     = (sp < dp) ? dp : sp;
        r.rec.valid       = known;
        r.rec.proto       = proto;
        r.rec.src_ip      = sip;
        r.rec.dst_ip      = dip;
        r.rec.src_l4_port = known ? sp : 16'd0;
        r.rec.dst_l4_port = known ? dp : 16'd0;
        r.rec.push        = is_tcp && ((flags & PSH_MASK) != 8'd0);
        r.rec.urgent      = is_tcp && ((flags & URG_MASK) != 8'd0);
        r.rec.len         = known ? len : 16'd0;
        r.hash            = known ? flow_key_hash(proto, lo, hi, seed) : 32'd0;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    task automatic compare_record(input flow_result_t want, input flow_result_t got);
        check_field("rec_valid",    32'(want.rec.valid),       32'(got.rec.valid));
        check_field("rec_proto",    32'(want.rec.proto),       32'(got.rec.proto));
        check_field("rec_src_ip",   want.rec.src_ip,           got.rec.src_ip);
        check_field("rec_dst_ip",   want.rec.dst_ip,           got.rec.dst_ip);
        check_field("rec_src_port", 32'(want.rec.src_l4_port), 32'(got.rec.src_l4_port));
        check_field("rec_dst_port", 32'(want.rec.dst_l4_port), 32'(got.rec.dst_l4_port));
        check_field("push_flag",    32'(want.rec.push),        32'(got.rec.push));
        check_field("urgent_flag",  32'(want.rec.urgent),      32'(got.rec.urgent));
        check_field("rec_len",      32'(want.rec.len),         32'(got.rec.len));
        check_field("flow_hash",    want.hash,                 got.hash);
    endtask

    // Watch both channels and the seed port; compare, then predict
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_records.delete();
            seed_now        = SEED_AFTER_RESET;
            fail_count      = 0;
            pending_records = 0;
            records_checked = 0;
            valid_records   = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                observed.rec.valid       = rec_valid;
                observed.rec.proto       = rec_proto;
                observed.rec.src_ip      = rec_src_ip;
                observed.rec.dst_ip      = rec_dst_ip;
                observed.rec.src_l4_port = rec_src_port;
                observed.rec.dst_l4_port = rec_dst_port;
                observed.rec.push        = push_flag;
                observed.rec.urgent      = urgent_flag;
                observed.rec.len         = rec_len;
                observed.hash            = flow_hash;
                if (expected_records.size() == 0)
                begin
                    $error("record arrived with none outstanding");
                    fail_count++;
                end
                else
                begin
                    oldest = expected_records.pop_front();
                    compare_record(oldest, observed);
                    records_checked++;
                    if (oldest.rec.valid)
                        valid_records++;
                end
            end
            if (in_valid && in_ready)
                expected_records.push_back(predict_record(ip_proto, src_ip, dst_ip,
                                                          src_l4_port, dst_l4_port,
                                                          l4_flags, frame_len,
                                                          seed_now));
            if (cfg_wr_en)
                seed_now = cfg_wr_data;
            pending_records = expected_records.size();
        end
    end

endmodule

@@ sim/flow_tuple_extract_hash_top_tb.sv @@
module flow_tuple_extract_hash_top_tb
    import fteh_pkg::*;
();

    localparam int          CYCLE_LIMIT     = 400000;
    localparam int          ITEMS_PER_PHASE = 125;
    localparam int          RANDOM_PHASES   = 8;
    localparam int          SETTLE_CYCLES   = 20;
    localparam logic [7:0]  PROTO_ICMP      = 8'd1;
    localparam logic [7:0]  FLAGS_PSH       = 8'h08;
    localparam logic [7:0]  FLAGS_URG       = 8'h20;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  ip_proto;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_l4_port;
    logic [15:0] dst_l4_port;
    logic [7:0]  l4_flags;
    logic [15:0] frame_len;
    logic        out_valid;
    logic        out_ready;
    logic        rec_valid;
    logic [7:0]  rec_proto;
    logic [31:0] rec_src_ip;
    logic [31:0] rec_dst_ip;
    logic [15:0] rec_src_port;
    logic [15:0] rec_dst_port;
    logic        push_flag;
    logic        urgent_flag;
    logic [15:0] rec_len;
    logic [31:0] flow_hash;

    int fail_count;
    int pending_records;
    int records_checked;
    int valid_records;
    int cycle_count = 0;
    int packets_sent;
    int seed_settings;
    int tx_idle_style;
    int rx_idle_style;

    flow_tuple_extract_hash_top dut (.*);

    flow_tuple_extract_hash_checker checker_i (.*);

    // Clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("flow_tuple_extract_hash_top_tb: FAIL");
            $finish;
        end
    end

    // Mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 20);
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_packet(input logic [7:0] p, input logic [31:0] sip,
                               input logic [31:0] dip, input logic [15:0] sp,
                               input logic [15:0] dp, input logic [7:0] flags,
                               input logic [15:0] len);
        int gap;
        gap = (tx_idle_style != 0) ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        ip_proto    <= p;
        src_ip      <= sip;
        dst_ip      <= dip;
        src_l4_port <= sp;
        dst_l4_port <= dp;
        l4_flags    <= flags;
        frame_len   <= len;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        packets_sent++;
    endtask

    // Mostly TCP/UDP with random content, some other protocols
    task automatic send_random_packet();
        logic [7:0]  p;
        logic [15:0] sp;
        logic [15:0] dp;
        int          sel;
        sel = $urandom_range(0, 99);
        if (sel < 45)
            p = PROTO_TCP;
        else if (sel < 85)
            p = PROTO_UDP;
        else
        begin
            p = 8'($urandom);
            while (p == PROTO_TCP || p == PROTO_UDP)
                p = 8'($urandom);
        end
        sp  = 16'($urandom);
        dp  = 16'($urandom);
        sel = $urandom_range(0, 19);
        case (sel)
            0: dp = sp;
            1: sp = 16'h0000;
            2: dp = 16'hffff;
            3: dp = sp + 16'd1;
            default: ;
        endcase
        send_packet(p, $urandom, $urandom, sp, dp, 8'($urandom), 16'($urandom));
    endtask

    // Seed may only change with the pipeline empty
    task automatic write_seed(input logic [31:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        seed_settings++;
    endtask

    task automatic drain_records();
        in_valid <= 1'b0;
        while (pending_records != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Receiver: ready with random stalls when enabled
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = (rx_idle_style != 0) ? pick_gap() : 0;
            if (stall == 0)
                out_ready <= 1'b1;
            else
            begin
                out_ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        logic [31:0] seed;
        packets_sent  = 0;
        seed_settings = 0;
        tx_idle_style = 1;
        rx_idle_style = 1;
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = 32'd0;
        in_valid      = 1'b0;
        ip_proto      = 8'd0;
        src_ip        = 32'd0;
        dst_ip        = 32'd0;
        src_l4_port   = 16'd0;
        dst_l4_port   = 16'd0;
        l4_flags      = 8'd0;
        frame_len     = 16'd0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed cases under the reset seed
        // all-zero and all-ones TCP
        send_packet(PROTO_TCP, 32'h0, 32'h0, 16'h0000, 16'h0000, 8'h00, 16'h0000);
        send_packet(PROTO_TCP, 32'hffffffff, 32'hffffffff, 16'hffff, 16'hffff,
                    8'hff, 16'hffff);
        // flags one at a time, then everything but PSH and URG
        send_packet(PROTO_TCP, 32'h0a000001, 32'h0a000002, 16'd1234, 16'd80,
                    FLAGS_PSH, 16'd60);
        send_packet(PROTO_TCP, 32'h0a000001, 32'h0a000002, 16'd1234, 16'd80,
                    FLAGS_URG, 16'd60);
        send_packet(PROTO_TCP, 32'h0a000001, 32'h0a000002, 16'd1234, 16'd80,
                    ~(FLAGS_PSH | FLAGS_URG), 16'd60);
        // swapped ports give the same hash
        send_packet(PROTO_TCP, 32'h0a000002, 32'h0a000001, 16'd80, 16'd1234,
                    FLAGS_PSH | FLAGS_URG, 16'd1500);
        // UDP: flags cleared, ports ordered both ways and equal; then one TCP case
        send_packet(PROTO_UDP, 32'hc0a80001, 32'h08080808, 16'd53, 16'd40000,
                    8'hff, 16'd512);
        send_packet(PROTO_UDP, 32'h08080808, 32'hc0a80001, 16'd40000, 16'd53,
                    8'hff, 16'd512);
        send_packet(PROTO_UDP, 32'h12345678, 32'h9abcdef0, 16'd5000, 16'd5000,
                    8'h00, 16'd100);
        send_packet(PROTO_UDP, 32'h0, 32'hffffffff, 16'hffff, 16'h0000, 8'h55,
                    16'hffff);
        send_packet(PROTO_TCP, 32'h55aa55aa, 32'haa55aa55, 16'h00ff, 16'hff00,
                    8'haa, 16'h8000);
        // other protocols, including the neighbours of TCP and UDP
        send_packet(8'h00, 32'h11111111, 32'h22222222, 16'd1, 16'd2, 8'hff, 16'd64);
        send_packet(8'hff, 32'hffffffff, 32'hffffffff, 16'hffff, 16'hffff, 8'hff,
                    16'hffff);
        send_packet(PROTO_ICMP, 32'h0a0a0a0a, 32'h0b0b0b0b, 16'd7, 16'd9, FLAGS_PSH,
                    16'd84);
        send_packet(PROTO_TCP - 8'd1, 32'h1, 32'h2, 16'd3, 16'd4, 8'hff, 16'd5);
        send_packet(PROTO_TCP + 8'd1, 32'h1, 32'h2, 16'd3, 16'd4, 8'hff, 16'd5);
        send_packet(PROTO_UDP - 8'd1, 32'h1, 32'h2, 16'd3, 16'd4, 8'hff, 16'd5);
        send_packet(PROTO_UDP + 8'd1, 32'h1, 32'h2, 16'd3, 16'd4, 8'hff, 16'd5);
        drain_records();

        // Random phases, each with a seed write and one of four idling patterns
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0: seed = 32'h00000000;
                1: seed = 32'hffffffff;
                2: seed = 32'd16;
                default: seed = $urandom;
            endcase
            write_seed(seed);
            tx_idle_style = phase % 2;
            rx_idle_style = (phase / 2) % 2;
            repeat (ITEMS_PER_PHASE) send_random_packet();
            drain_records();
        end

        $display("Sent %0d packets under %0d seed settings plus the reset seed.",
                 packets_sent, seed_settings);
        $display("Checked %0d records: %0d TCP/UDP, %0d other protocols.",
                 records_checked, valid_records, records_checked - valid_records);
        if (fail_count == 0)
            $display("flow_tuple_extract_hash_top_tb: PASS");
        else
            $display("flow_tuple_extract_hash_top_tb: FAIL");
        $finish;
    end

endmodule

@@ flow_tuple_extract_hash_top.f @@
src/fteh_pkg.sv
src/flow_tuple_extract_hash_top.sv
sim/flow_tuple_extract_hash_checker.sv
sim/flow_tuple_extract_hash_top_tb.sv
